/* src/cmb_pkg.sv */
// Shared types and constants of the Comba bignum multiplier.
`default_nettype none
package cmb_pkg;

    localparam int PORT_DIGIT_W = 32;  // width of a digit on the ports
    localparam int IDX_W        = 5;   // operand digit address, widest case
    localparam int COL_W        = 6;   // product column / length, widest case

    typedef enum logic [1:0] {
        CMD_LOAD_A   = 2'd0,
        CMD_LOAD_B   = 2'd1,
        CMD_MULTIPLY = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COLUMNS,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]              command;
        logic [PORT_DIGIT_W-1:0] digit_value;
        logic [IDX_W-1:0]        digit_index;
        logic [COL_W-1:0]        a_length;
        logic [COL_W-1:0]        b_length;
    } t_in;

    typedef struct packed {
        logic [PORT_DIGIT_W-1:0] product_digit;
        logic [COL_W-1:0]        product_index;
        logic                    last_digit;
    } t_out;

    // One multiply-accumulate beat issued into the datapath pipeline.
    typedef struct packed {
        logic             valid;
        logic             col_end;    // close the column after this beat
        logic             zero_prod;  // column with no digit product
        logic [IDX_W-1:0] a_addr;
        logic [IDX_W-1:0] b_addr;
        logic [COL_W-1:0] col;
    } t_mac_cmd;

    // One product digit read for the result port.
    typedef struct packed {
        logic             valid;
        logic             zero;       // product is zero: send a lone zero digit
        logic [COL_W-1:0] addr;
        logic             last;
    } t_emit_cmd;

    typedef struct packed {
        logic      wr_a;
        logic      wr_b;
        logic      clear;
        t_mac_cmd  mac;
        t_emit_cmd emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic             any;        // some product digit is nonzero
        logic [COL_W-1:0] top;        // column of the highest nonzero digit
    } t_dp_status;

endpackage
`default_nettype wire

/* src/cmb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/cmb_ctrl.sv */
// Controller of the Comba bignum multiplier: command decode and column sequencing.
`default_nettype none
module cmb_ctrl #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cmb_pkg::t_in        i_item,
    input  cmb_pkg::t_dp_status i_status,
    output logic                o_busy,
    output cmb_pkg::t_ctl_cmd   o_cmd
);
    import cmb_pkg::*;

    localparam logic [COL_W-1:0] MAX_LEN = COL_W'(MAX_DIGITS);

    t_state           r_state, n_state;
    logic [COL_W-1:0] r_la, n_la, r_lb, n_lb;
    logic [COL_W-1:0] r_ix, n_ix;
    logic [IDX_W-1:0] r_i, n_i;
    logic [COL_W-1:0] r_k, n_k;
    logic             r_drain, n_drain;

    logic [COL_W-1:0] w_la_sat, w_lb_sat;
    logic [COL_W:0]   w_pa_m1, w_next_col, w_lo_next;
    logic [COL_W-1:0] w_hi, w_j;
    logic             w_last_col, w_col_end, w_idx_ok, w_emit_last;

    assign w_la_sat = (i_item.a_length > MAX_LEN) ? MAX_LEN : i_item.a_length;
    assign w_lb_sat = (i_item.b_length > MAX_LEN) ? MAX_LEN : i_item.b_length;
    assign w_idx_ok = (COL_W'(i_item.digit_index) < MAX_LEN);

    // Column bounds: a digits run lo..hi, b digit is column minus a index.
    assign w_pa_m1    = (COL_W + 1)'(r_la) + (COL_W + 1)'(r_lb) - (COL_W + 1)'(1);
    assign w_last_col = ({1'b0, r_ix} == w_pa_m1);
    assign w_hi       = (r_ix < r_la) ? r_ix : (r_la - COL_W'(1));
    assign w_col_end  = (COL_W'(r_i) == w_hi);
    assign w_next_col = (COL_W + 1)'(r_ix) + (COL_W + 1)'(1);
    assign w_lo_next  = (w_next_col >= (COL_W + 1)'(r_lb))
                        ? (w_next_col - (COL_W + 1)'(r_lb) + (COL_W + 1)'(1))
                        : '0;
    assign w_j        = r_ix - COL_W'(r_i);
    assign w_emit_last = !i_status.any || (r_k == i_status.top);

    // Next state and counters.
    always_comb begin
        n_state = r_state;
        n_la    = r_la;
        n_lb    = r_lb;
        n_ix    = r_ix;
        n_i     = r_i;
        n_k     = r_k;
        n_drain = r_drain;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && (t_cmd'(i_item.command) == CMD_MULTIPLY)) begin
                    n_la = w_la_sat;
                    n_lb = w_lb_sat;
                    n_ix = '0;
                    n_i  = '0;
                    n_k  = '0;
                    if ((w_la_sat == '0) || (w_lb_sat == '0)) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_COLUMNS;
                    end
                end
            end
            ST_COLUMNS: begin
                if (w_last_col) begin
                    n_drain = 1'b0;
                    n_state = ST_DRAIN;
                end else if (w_col_end) begin
                    n_ix = w_next_col[COL_W-1:0];
                    n_i  = w_lo_next[IDX_W-1:0];
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_k = r_k + COL_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (t_cmd'(i_item.command))
                        CMD_LOAD_A:   o_cmd.wr_a  = w_idx_ok;
                        CMD_LOAD_B:   o_cmd.wr_b  = w_idx_ok;
                        CMD_MULTIPLY: o_cmd.clear = 1'b1;
                        default:      o_cmd.clear = 1'b0;
                    endcase
                end
            end
            ST_COLUMNS: begin
                o_cmd.mac.valid     = 1'b1;
                o_cmd.mac.col       = r_ix;
                o_cmd.mac.col_end   = w_last_col || w_col_end;
                o_cmd.mac.zero_prod = w_last_col;
                o_cmd.mac.a_addr    = r_i;
                o_cmd.mac.b_addr    = w_j[IDX_W-1:0];
            end
            ST_EMIT: begin
                o_cmd.emit.valid = 1'b1;
                o_cmd.emit.zero  = !i_status.any;
                o_cmd.emit.addr  = i_status.any ? r_k : '0;
                o_cmd.emit.last  = w_emit_last;
            end
            ST_DRAIN: o_cmd = '0;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_la    <= '0;
            r_lb    <= '0;
            r_ix    <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_la    <= n_la;
            r_lb    <= n_lb;
            r_ix    <= n_ix;
            r_i     <= n_i;
            r_k     <= n_k;
            r_drain <= n_drain;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

/* src/cmb_dpath.sv */
// Datapath of the Comba bignum multiplier: digit stores, multiplier, column accumulator.
`default_nettype none
module cmb_dpath #(
    parameter int DIGIT_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cmb_pkg::t_ctl_cmd                   i_cmd,
    input  logic [cmb_pkg::PORT_DIGIT_W-1:0]    i_digit_value,
    input  logic [cmb_pkg::IDX_W-1:0]           i_digit_index,
    output cmb_pkg::t_dp_status                 o_status,
    output logic                                o_valid,
    output cmb_pkg::t_out                       o_result
);
    import cmb_pkg::*;

    localparam int DW    = (DIGIT_BITS < PORT_DIGIT_W) ? DIGIT_BITS : PORT_DIGIT_W;
    localparam int AW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PD    = 2 * MAX_DIGITS;
    localparam int PW    = $clog2(PD);
    localparam int ACC_W = 2 * DW + 6;   // column sum of up to 32 products plus carry

    logic [DW-1:0]         w_a, w_b, w_pdig;
    t_mac_cmd              r_s1, r_s2;
    t_emit_cmd             r_e;
    logic [2*DW-1:0]       r_prod;
    logic [ACC_W-1:0]      r_acc, w_sum;
    logic                  w_col_we, w_nonzero;
    logic                  r_any;
    logic [PW-1:0]         r_top;

    cmb_ram #(.WIDTH(DW), .DEPTH(MAX_DIGITS)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a),
        .i_waddr (i_digit_index[AW-1:0]),
        .i_wdata (i_digit_value[DW-1:0]),
        .i_raddr (i_cmd.mac.a_addr[AW-1:0]),
        .o_rdata (w_a)
    );

    cmb_ram #(.WIDTH(DW), .DEPTH(MAX_DIGITS)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b),
        .i_waddr (i_digit_index[AW-1:0]),
        .i_wdata (i_digit_value[DW-1:0]),
        .i_raddr (i_cmd.mac.b_addr[AW-1:0]),
        .o_rdata (w_b)
    );

    cmb_ram #(.WIDTH(DW), .DEPTH(PD)) u_p_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (r_s2.col[PW-1:0]),
        .i_wdata (w_sum[DW-1:0]),
        .i_raddr (i_cmd.emit.addr[PW-1:0]),
        .o_rdata (w_pdig)
    );

    // Beat tags follow the data through read and multiply stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_e  <= '0;
        end else begin
            r_s1 <= i_cmd.mac;
            r_s2 <= r_s1;
            r_e  <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.zero_prod) begin
            r_prod <= '0;
        end else begin
            r_prod <= {{DW{1'b0}}, w_a} * {{DW{1'b0}}, w_b};
        end
    end

    assign w_sum     = r_acc + ACC_W'(r_prod);
    assign w_col_we  = r_s2.valid && r_s2.col_end;
    assign w_nonzero = |w_sum[DIGIT_BITS-1:0];

    // Accumulate; at column end drop the low digit and keep the carry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_acc <= '0;
            r_any <= 1'b0;
            r_top <= '0;
        end else if (r_s2.valid) begin
            r_acc <= r_s2.col_end ? (w_sum >> DIGIT_BITS) : w_sum;
            if (w_col_we && w_nonzero) begin
                r_any <= 1'b1;
                r_top <= r_s2.col[PW-1:0];
            end
        end
    end

    assign o_status.any = r_any;
    assign o_status.top = COL_W'(r_top);

    assign o_valid                = r_e.valid;
    assign o_result.product_digit = r_e.zero ? '0 : PORT_DIGIT_W'(w_pdig);
    assign o_result.product_index = r_e.addr;
    assign o_result.last_digit    = r_e.last;

endmodule
`default_nettype wire

/* src/comba_bignum_multiplier.sv */
// Top level of the Comba bignum multiplier: controller plus datapath.
//
//  channel   signals                    beat taken when
//  --------  -------------------------  -----------------------------
//  command   i_start, i_item, o_busy    i_start high and o_busy low
//  result    o_valid, o_result          every cycle o_valid is high
//
// A load beat leaves the block idle, so it is free again at once.
// A multiply of la by lb digits walks la*lb product beats plus one
// beat for the empty top column through one 32x32 multiplier, waits
// for the accumulator pipeline to drain, then sends the trimmed
// product one digit a cycle (top+1 digits, or one zero digit); with a
// zero length it skips straight to the single zero digit.
// Reset is synchronous, active low; digit stores are not cleared.
// The result side cannot stall: each result is shown for one cycle only.
`default_nettype none
module comba_bignum_multiplier #(
    parameter int DIGIT_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cmb_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_valid,
    output cmb_pkg::t_out o_result
);
    import cmb_pkg::*;

    t_ctl_cmd   w_cmd;
    t_dp_status w_status;

    // Sequence loads, product columns and digit readout.
    cmb_ctrl #(.MAX_DIGITS(MAX_DIGITS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .i_status (w_status),
        .o_busy   (o_busy),
        .o_cmd    (w_cmd)
    );

    // Hold digits, multiply, accumulate columns and store the product.
    cmb_dpath #(.DIGIT_BITS(DIGIT_BITS), .MAX_DIGITS(MAX_DIGITS)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_digit_value (i_item.digit_value),
        .i_digit_index (i_item.digit_index),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the Comba bignum multiplier: directed table, then random beats.
`default_nettype none
module tb_top;
    import cmb_pkg::*;

    // Command code the block ignores (not part of t_cmd).
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_DIGITS    = 32;
    localparam int ITEM_TARGET = 320;
    localparam int CYCLE_LIMIT = 4_000_000;

    // Expectation carried with each driven beat. When typed is set, the
    // typed product digits replace what the column predictor works out.
    typedef struct packed {
        logic       typed;
        logic [1:0] n_typed;
        t_out       w0;
        t_out       w1;
    } t_result_note;

    typedef struct packed {
        t_in          item;
        t_result_note note;
    } t_stim_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_start;
    t_in   i_item;
    logic  o_busy;
    logic  o_valid;
    t_out  o_result;

    comba_bignum_multiplier u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Predictor state: its own copy of both digit stores.
    logic [31:0] a_store [N_DIGITS];
    logic [31:0] b_store [N_DIGITS];

    // Product digits still to come out of the block, oldest first.
    t_out         product_digits_due[$];
    // Digits of the latest multiply, as the column predictor computes them.
    t_out         column_digits[$];
    // One note per driven beat, consumed when the block takes the beat.
    t_result_note beat_notes[$];

    // Stimulus side bookkeeping: which digits have ever been loaded, so that
    // no multiply reads a digit that was never written.
    bit a_written [N_DIGITS];
    bit b_written [N_DIGITS];

    int fail_count;
    int cycle_count;
    int items_taken;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_out digit_out(logic [31:0] d, logic [5:0] col, logic last);
        t_out r;
        r.product_digit = d;
        r.product_index = col;
        r.last_digit    = last;
        return r;
    endfunction

    function automatic t_stim_row row(logic [1:0] cmd, logic [31:0] val, logic [4:0] idx,
                                      logic [5:0] la, logic [5:0] lb, logic typed,
                                      logic [1:0] n, t_out w0, t_out w1);
        t_stim_row s;
        s.item.command      = cmd;
        s.item.digit_value  = val;
        s.item.digit_index  = idx;
        s.item.a_length     = la;
        s.item.b_length     = lb;
        s.note.typed        = typed;
        s.note.n_typed      = n;
        s.note.w0           = w0;
        s.note.w1           = w1;
        return s;
    endfunction

    // Fully random beat; also used to fill the fields a command ignores.
    function automatic t_in scrambled_item();
        t_in it;
        it.command     = 2'($urandom_range(0, 3));
        it.digit_value = $urandom;
        it.digit_index = 5'($urandom_range(0, 31));
        it.a_length    = 6'($urandom_range(0, 63));
        it.b_length    = 6'($urandom_range(0, 63));
        return it;
    endfunction

    // Column-wise multiply: apply one accepted beat to the predictor. Loads
    // update the stores; a multiply leaves its trimmed digits in column_digits.
    function automatic void comba_predict(t_in it);
        logic [191:0] acc;
        logic [31:0]  col_digit [2*N_DIGITS];
        int           la, lb, n_cols, lo_i, hi_i, top;
        bit           nonzero;
        column_digits.delete();
        if (it.command == CMD_LOAD_A) begin
            a_store[it.digit_index] = it.digit_value;
            return;
        end
        if (it.command == CMD_LOAD_B) begin
            b_store[it.digit_index] = it.digit_value;
            return;
        end
        if (it.command != CMD_MULTIPLY) return;

        // Saturate lengths to the store depth.
        la = (it.a_length > N_DIGITS) ? N_DIGITS : int'(it.a_length);
        lb = (it.b_length > N_DIGITS) ? N_DIGITS : int'(it.b_length);
        acc = '0;
        n_cols = (la != 0 && lb != 0) ? la + lb : 0;
        for (int ix = 0; ix < n_cols; ix++) begin
            lo_i = (ix >= lb) ? ix - (lb - 1) : 0;
            hi_i = (ix < la) ? ix : la - 1;
            for (int i = lo_i; i <= hi_i; i++)
                acc = acc + 192'(64'(a_store[i]) * 64'(b_store[ix - i]));
            // Keep the low digit, then shift the accumulator down one digit.
            col_digit[ix] = acc[31:0];
            acc = acc >> 32;
        end

        // Trim leading zero digits.
        top = 0;
        nonzero = 1'b0;
        for (int ix = 0; ix < n_cols; ix++) begin
            if (col_digit[ix] != '0) begin
                top = ix;
                nonzero = 1'b1;
            end
        end
        if (!nonzero) begin
            column_digits.push_back(digit_out('0, '0, 1'b1));
            return;
        end
        for (int k = 0; k <= top; k++)
            column_digits.push_back(digit_out(col_digit[k], 6'(k), k == top));
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
        end
    endfunction

    // Watch both channels at every rising edge. Predict on the edge that takes
    // a command beat; check every result beat against the oldest expectation.
    always @(posedge i_clk) begin : watch
        t_result_note note;
        t_out         want;
        cycle_count++;
        if (i_rst_n && i_start && !o_busy) begin
            note = (beat_notes.size() != 0) ? beat_notes.pop_front() : '0;
            comba_predict(i_item);
            if (note.typed) begin
                if (note.n_typed >= 1) product_digits_due.push_back(note.w0);
                if (note.n_typed >= 2) product_digits_due.push_back(note.w1);
            end else begin
                foreach (column_digits[k]) product_digits_due.push_back(column_digits[k]);
            end
        end
        if (i_rst_n && o_valid) begin
            if (product_digits_due.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result beat: expected none actual %h",
                         $time, o_result);
            end else begin
                want = product_digits_due.pop_front();
                check_field("product_digit", want.product_digit, o_result.product_digit);
                check_field("product_index", 32'(want.product_index),
                            32'(o_result.product_index));
                check_field("last_digit", 32'(want.last_digit), 32'(o_result.last_digit));
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Hold the beat on the command port until the block takes it, then
    // maybe drop start for a short random gap.
    task automatic issue_beat(input t_in it, input t_result_note note);
        bit calm;
        beat_notes.push_back(note);
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (it.command == CMD_LOAD_A) a_written[it.digit_index] = 1'b1;
        if (it.command == CMD_LOAD_B) b_written[it.digit_index] = 1'b1;
        if (it.command != CMD_UNUSED) items_taken++;
        // Keep a long stretch in the middle of the run free of gaps.
        calm = (items_taken >= 120 && items_taken < 200);
        if (!calm && $urandom_range(0, 99) < 32) begin
            i_start <= 1'b0;
            i_item  <= scrambled_item();
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every expected product digit has arrived.
    task automatic drain_products();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (product_digits_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic int loaded_prefix(bit w [N_DIGITS]);
        int n;
        n = 0;
        while (n < N_DIGITS && w[n]) n++;
        return n;
    endfunction

    // Pick a multiply length that reads only loaded digits; codes above the
    // store depth are legal once the whole store is loaded.
    function automatic logic [5:0] pick_length(int prefix);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (prefix == N_DIGITS && r == 1) return 6'($urandom_range(33, 63));
        if (r < 6) return 6'(prefix);
        return 6'($urandom_range(0, prefix));
    endfunction

    function automatic logic [31:0] pick_digit();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2:       return '1;
            3:       return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in load_beat(logic [1:0] cmd, int idx);
        t_in it;
        it = scrambled_item();
        it.command     = cmd;
        it.digit_index = 5'(idx);
        it.digit_value = pick_digit();
        return it;
    endfunction

    initial begin : stimulus
        t_stim_row    directed[$];
        t_result_note none;
        t_out         zero_prod;
        t_in          it;
        int           seq, a_len, b_len, n_mul;

        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;
        fail_count   = 0;
        cycle_count  = 0;
        items_taken  = 0;
        none = '0;
        zero_prod = digit_out('0, '0, 1'b1);

        // Directed table. Typed rows carry the product that can be read off
        // directly; the rest go through the predictor.
        directed.push_back(row(CMD_MULTIPLY, '0, '0, 6'd0, 6'd0, 1'b1, 2'd1, zero_prod, '0));
        directed.push_back(row(CMD_UNUSED, '1, 5'd31, 6'd63, 6'd63, 1'b1, 2'd0, '0, '0));
        directed.push_back(row(CMD_LOAD_A, '1, 5'd0, 6'd0, 6'd0, 1'b0, 2'd0, '0, '0));
        directed.push_back(row(CMD_LOAD_B, '1, 5'd0, 6'd63, 6'd63, 1'b0, 2'd0, '0, '0));
        // Largest single digits: ffffffff squared spans two digits.
        directed.push_back(row(CMD_MULTIPLY, '0, '0, 6'd1, 6'd1, 1'b1, 2'd2,
                               digit_out(32'h0000_0001, 6'd0, 1'b0),
                               digit_out(32'hffff_fffe, 6'd1, 1'b1)));
        directed.push_back(row(CMD_MULTIPLY, '1, 5'd31, 6'd0, 6'd1, 1'b1, 2'd1,
                               zero_prod, '0));
        directed.push_back(row(CMD_MULTIPLY, '0, '0, 6'd1, 6'd0, 1'b1, 2'd1, zero_prod, '0));
        // Operand with all digits zero.
        directed.push_back(row(CMD_LOAD_A, '0, 5'd0, 6'd0, 6'd0, 1'b0, 2'd0, '0, '0));
        directed.push_back(row(CMD_MULTIPLY, '0, '0, 6'd1, 6'd1, 1'b1, 2'd1, zero_prod, '0));
        directed.push_back(row(CMD_LOAD_A, 32'd3, 5'd0, 6'd0, 6'd0, 1'b0, 2'd0, '0, '0));
        directed.push_back(row(CMD_LOAD_B, 32'd5, 5'd0, 6'd0, 6'd0, 1'b0, 2'd0, '0, '0));
        directed.push_back(row(CMD_MULTIPLY, '0, '0, 6'd1, 6'd1, 1'b1, 2'd1,
                               digit_out(32'd15, 6'd0, 1'b1), '0));
        directed.push_back(row(CMD_LOAD_A, 32'hdead_beef, 5'd1, 6'd0, 6'd0, 1'b0, 2'd0,
                               '0, '0));
        directed.push_back(row(CMD_LOAD_B, '0, 5'd1, 6'd0, 6'd0, 1'b0, 2'd0, '0, '0));
        // Zero top digit of B: the product loses its top column to trimming.
        directed.push_back(row(CMD_MULTIPLY, '0, '0, 6'd2, 6'd2, 1'b0, 2'd0, '0, '0));
        directed.push_back(row(CMD_MULTIPLY, '0, '0, 6'd2, 6'd1, 1'b0, 2'd0, '0, '0));
        directed.push_back(row(CMD_LOAD_B, '1, 5'd1, 6'd0, 6'd0, 1'b0, 2'd0, '0, '0));
        directed.push_back(row(CMD_MULTIPLY, '0, '0, 6'd2, 6'd2, 1'b0, 2'd0, '0, '0));
        directed.push_back(row(CMD_LOAD_A, 32'ha5a5_a5a5, 5'd31, 6'd0, 6'd0, 1'b0, 2'd0,
                               '0, '0));
        directed.push_back(row(CMD_LOAD_B, 32'h5a5a_5a5a, 5'd31, 6'd0, 6'd0, 1'b0, 2'd0,
                               '0, '0));
        directed.push_back(row(CMD_MULTIPLY, '1, 5'd31, 6'd2, 6'd2, 1'b0, 2'd0, '0, '0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) issue_beat(directed[k].item, directed[k].note);
        drain_products();

        // Random part: load sequences with random content, then multiplies
        // over what is loaded; sprinkle stray loads and ignored commands.
        items_taken = 0;
        seq = 0;
        while (items_taken < ITEM_TARGET) begin
            seq++;
            // Hold off once mid-run until every product digit is back.
            if (seq == 6) drain_products();
            a_len = (seq == 1 || $urandom_range(0, 11) == 0) ? N_DIGITS : $urandom_range(1, 6);
            b_len = (seq == 1 || $urandom_range(0, 11) == 0) ? N_DIGITS : $urandom_range(1, 6);
            for (int k = 0; k < N_DIGITS && (k < a_len || k < b_len); k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    it = scrambled_item();
                    if (it.command == CMD_MULTIPLY) it.command = CMD_UNUSED;
                    issue_beat(it, none);
                end
                if (k < a_len) issue_beat(load_beat(CMD_LOAD_A, k), none);
                if (k < b_len) issue_beat(load_beat(CMD_LOAD_B, k), none);
            end
            n_mul = $urandom_range(1, 3);
            repeat (n_mul) begin
                it = scrambled_item();
                it.command  = CMD_MULTIPLY;
                it.a_length = pick_length(loaded_prefix(a_written));
                it.b_length = pick_length(loaded_prefix(b_written));
                issue_beat(it, none);
            end
        end

        // Drain, then give the block time to show any stray result beat.
        drain_products();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
src/cmb_pkg.sv
src/cmb_ram.sv
src/cmb_ctrl.sv
src/cmb_dpath.sv
src/comba_bignum_multiplier.sv
verif/tb_top.sv
